### rtl/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg: shared definitions for the sample voice mixer
// Field widths, command codes, controller states and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int VOICES_DEF       = 4;
  localparam int SAMPLE_WORDS_DEF = 65536;

  localparam int CMD_W    = 2;
  localparam int VOICE_W  = 4;
  localparam int ADDR_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 17;
  localparam int RATE_W   = 18;
  localparam int PRIO_W   = 8;
  localparam int POS_W    = 18;
  localparam int FRAC_W   = 16;
  localparam int MASK_W   = 16;

  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_RDA,
    ST_RDB,
    ST_RDC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic vstart;
    logic stop_all;
    logic tick_init;
    logic advance;
    logic read_first;
    logic read_second;
    logic add_first;
    logic add_second;
    logic next_voice;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic stereo;
    logic last;
  } dp_stat_t;

endpackage

### rtl/svm_ctrl.sv
// ----------------------------------------------------------------------------
// svm_ctrl: sequencer of the sample voice mixer
// Decodes accepted commands and walks the voices one at a time on a tick.
// ----------------------------------------------------------------------------
module svm_ctrl
  import svm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CMD_W-1:0] in_command,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd,
  output logic             busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && cmd_code_t'(in_command) == CMD_TICK) begin
          state_nxt = ST_ADV;
        end
      end
      ST_ADV: begin
        if (stat.hit) begin
          state_nxt = ST_RDA;
        end else begin
          state_nxt = stat.last ? ST_OUT : ST_ADV;
        end
      end
      ST_RDA: begin
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        if (stat.stereo) begin
          state_nxt = ST_RDC;
        end else begin
          state_nxt = stat.last ? ST_OUT : ST_ADV;
        end
      end
      ST_RDC: begin
        state_nxt = stat.last ? ST_OUT : ST_ADV;
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd  = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_code_t'(in_command))
            CMD_LOAD:  cmd.load      = 1'b1;
            CMD_START: cmd.vstart    = 1'b1;
            CMD_STOP:  cmd.stop_all  = 1'b1;
            CMD_TICK:  cmd.tick_init = 1'b1;
            default:   cmd           = '0;
          endcase
        end
      end
      ST_ADV: begin
        cmd.advance    = 1'b1;
        cmd.next_voice = !stat.hit;
      end
      ST_RDA: begin
        cmd.read_first = 1'b1;
      end
      ST_RDB: begin
        cmd.read_second = stat.stereo;
        cmd.add_first   = 1'b1;
        cmd.next_voice  = !stat.stereo;
      end
      ST_RDC: begin
        cmd.add_second = 1'b1;
        cmd.next_voice = 1'b1;
      end
      ST_OUT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // A first read is always followed by the cycle that collects its data.
  a_rda_then_rdb: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RDA |=> state_r == ST_RDB)
    else $error("first read not followed by its collect cycle");

  // The right-channel collect only follows a stereo first collect.
  a_rdc_after_rdb: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RDC |-> $past(state_r) == ST_RDB && $past(stat.stereo))
    else $error("second collect without a stereo voice");

  // A tick ends with exactly one emit cycle and then returns to idle.
  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |=> state_r == ST_IDLE)
    else $error("emit cycle not followed by idle");

endmodule

### rtl/svm_datapath.sv
// ----------------------------------------------------------------------------
// svm_datapath: voice registers, sample memory and mix accumulators
// Holds per-voice playback state, advances one voice per step, reads the
// sample memory and forms the saturated left and right mix.
// ----------------------------------------------------------------------------
module svm_datapath
  import svm_pkg::*;
#(
  parameter int VOICES       = VOICES_DEF,
  parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic [VOICE_W-1:0]         in_voice,
  input  logic [ADDR_W-1:0]          in_address,
  input  logic signed [SAMPLE_W-1:0] in_sample_word,
  input  logic [LEN_W-1:0]           in_frame_count,
  input  logic                       in_stereo,
  input  logic [RATE_W-1:0]          in_rate_step,
  input  logic                       in_looping,
  input  logic [PRIO_W-1:0]          in_priority_req,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_left_out,
  output logic signed [SAMPLE_W-1:0] out_right_out,
  output logic [MASK_W-1:0]          out_active_voices
);

  localparam int VI_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW    = $clog2(SAMPLE_WORDS);
  localparam int ACC_W = RATE_W + 1;
  localparam int SUM_W = SAMPLE_W + $clog2(VOICES) + 1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(SAT_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(SAT_MIN);

  // Per-voice state.
  logic                active_r [VOICES];
  logic [PRIO_W-1:0]   prio_r   [VOICES];
  logic [POS_W-1:0]    pos_r    [VOICES];
  logic [FRAC_W-1:0]   frac_r   [VOICES];
  logic [ADDR_W-1:0]   base_r   [VOICES];
  logic [LEN_W-1:0]    len_r    [VOICES];
  logic                stereo_r [VOICES];
  logic [RATE_W-1:0]   rate_r   [VOICES];
  logic                loop_r   [VOICES];

  logic [VI_W-1:0]     vc_r;

  logic [SAMPLE_W-1:0] mem [SAMPLE_WORDS];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_ok_r;

  logic signed [SUM_W-1:0] sum_l_r;
  logic signed [SUM_W-1:0] sum_r_r;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_left_r;
  logic [SAMPLE_W-1:0] out_right_r;
  logic [MASK_W-1:0]   out_mask_r;

  // Start decode.
  logic            voice_ok;
  logic [VI_W-1:0] sv;
  logic            start_take;

  assign voice_ok   = {1'b0, in_voice} < (VOICE_W + 1)'(VOICES);
  assign sv         = in_voice[VI_W-1:0];
  assign start_take = cmd.vstart && voice_ok && !(active_r[sv] && prio_r[sv] > in_priority_req);

  // Phase advance of the current voice.
  logic [ACC_W-1:0] acc;
  logic [POS_W-1:0] pos_new;
  logic             at_end;

  assign acc     = ACC_W'(frac_r[vc_r]) + ACC_W'(rate_r[vc_r]);
  assign pos_new = pos_r[vc_r] + POS_W'(acc[ACC_W-1:FRAC_W]);
  assign at_end  = pos_new >= POS_W'(len_r[vc_r]);

  // Sample addresses wrap at 16 bits.
  logic [ADDR_W-1:0] frame_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_ok;
  logic              load_ok;

  always_comb begin
    if (stereo_r[vc_r]) begin
      frame_addr = base_r[vc_r] + {pos_r[vc_r][ADDR_W-2:0], 1'b0};
    end else begin
      frame_addr = base_r[vc_r] + pos_r[vc_r][ADDR_W-1:0];
    end
  end

  assign rd_addr = cmd.read_second ? frame_addr + ADDR_W'(1) : frame_addr;
  assign rd_ok   = {1'b0, rd_addr} < (ADDR_W + 1)'(SAMPLE_WORDS);
  assign load_ok = {1'b0, in_address} < (ADDR_W + 1)'(SAMPLE_WORDS);

  assign stat.hit    = active_r[vc_r] && !at_end;
  assign stat.stereo = stereo_r[vc_r];
  assign stat.last   = (vc_r == VI_W'(VOICES - 1));

  // Sample memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[in_address[AW-1:0]] <= in_sample_word;
    end
    if (cmd.read_first || cmd.read_second) begin
      rd_data_r <= mem[rd_addr[AW-1:0]];
      rd_ok_r   <= rd_ok;
    end
  end

  // Control state of the voices.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        active_r[i] <= 1'b0;
        prio_r[i]   <= '0;
      end
      vc_r <= '0;
    end else begin
      if (cmd.stop_all) begin
        for (int i = 0; i < VOICES; i++) begin
          active_r[i] <= 1'b0;
          prio_r[i]   <= '0;
        end
      end
      if (start_take) begin
        active_r[sv] <= 1'b1;
        prio_r[sv]   <= in_priority_req;
      end
      if (cmd.advance && active_r[vc_r] && at_end && !loop_r[vc_r]) begin
        active_r[vc_r] <= 1'b0;
      end
      if (cmd.tick_init) begin
        vc_r <= '0;
      end else if (cmd.next_voice && !stat.last) begin
        vc_r <= vc_r + VI_W'(1);
      end
    end
  end

  // Playback registers of the voices.
  always_ff @(posedge clk) begin
    if (start_take) begin
      base_r[sv]   <= in_address;
      len_r[sv]    <= in_frame_count;
      stereo_r[sv] <= in_stereo;
      rate_r[sv]   <= in_rate_step;
      loop_r[sv]   <= in_looping;
      pos_r[sv]    <= '0;
      frac_r[sv]   <= '0;
    end else if (cmd.advance && active_r[vc_r]) begin
      if (at_end && loop_r[vc_r]) begin
        pos_r[vc_r]  <= '0;
        frac_r[vc_r] <= '0;
      end else begin
        pos_r[vc_r]  <= pos_new;
        frac_r[vc_r] <= acc[FRAC_W-1:0];
      end
    end
  end

  // Mix accumulators. An out-of-range read contributes zero.
  logic signed [SAMPLE_W-1:0] samp;
  logic signed [SUM_W-1:0]    samp_ext;

  assign samp     = rd_ok_r ? $signed(rd_data_r) : '0;
  assign samp_ext = SUM_W'(samp);

  always_ff @(posedge clk) begin
    if (cmd.tick_init) begin
      sum_l_r <= '0;
      sum_r_r <= '0;
    end else begin
      if (cmd.add_first) begin
        sum_l_r <= sum_l_r + samp_ext;
        if (!stereo_r[vc_r]) begin
          sum_r_r <= sum_r_r + samp_ext;
        end
      end
      if (cmd.add_second) begin
        sum_r_r <= sum_r_r + samp_ext;
      end
    end
  end

  // Saturation and the active mask.
  logic [SAMPLE_W-1:0] sat_l;
  logic [SAMPLE_W-1:0] sat_r;
  logic [MASK_W-1:0]   mask;

  always_comb begin
    priority if (sum_l_r > SUM_MAX) begin
      sat_l = SUM_MAX[SAMPLE_W-1:0];
    end else if (sum_l_r < SUM_MIN) begin
      sat_l = SUM_MIN[SAMPLE_W-1:0];
    end else begin
      sat_l = sum_l_r[SAMPLE_W-1:0];
    end
    priority if (sum_r_r > SUM_MAX) begin
      sat_r = SUM_MAX[SAMPLE_W-1:0];
    end else if (sum_r_r < SUM_MIN) begin
      sat_r = SUM_MIN[SAMPLE_W-1:0];
    end else begin
      sat_r = sum_r_r[SAMPLE_W-1:0];
    end
    mask = '0;
    for (int i = 0; i < VOICES; i++) begin
      mask[i] = active_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_left_r  <= sat_l;
      out_right_r <= sat_r;
      out_mask_r  <= mask;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_out      = $signed(out_left_r);
  assign out_right_out     = $signed(out_right_r);
  assign out_active_voices = out_mask_r;

endmodule

### rtl/sample_voice_mixer.sv
// ----------------------------------------------------------------------------
// sample_voice_mixer: multi-voice PCM sample playback mixer
// A command is accepted at a rising edge where start is high and busy is low.
// Load writes one word of sample memory, start arms a voice, stop silences
// all voices, and tick mixes one output frame.
//
// Only a tick produces a transaction on the result side: out_valid is high
// for exactly one cycle with the saturated left and right mix and the mask
// of voices still playing. The receiver cannot stall and must take it then.
//
// Timing: load, start and stop complete at the edge that accepts them; busy
// stays low and the next command can be accepted on the following edge. A
// tick walks the voices one at a time through the single sample memory
// port: a voice that is idle or reaches its end passes only the advance
// state, a mono voice passes advance, first read and collect, and a stereo
// voice adds the right-channel collect; a final output state forms the
// result. The result strobe rises at the same edge at which busy falls and
// is taken at the next edge.
//
// Reset clears all voice activity and priorities. The sample memory is not
// cleared; words must be loaded before a voice plays them.
// ----------------------------------------------------------------------------
module sample_voice_mixer
  import svm_pkg::*;
#(
  parameter int VOICES       = VOICES_DEF,
  parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [CMD_W-1:0]           in_command,
  input  logic [VOICE_W-1:0]         in_voice,
  input  logic [ADDR_W-1:0]          in_address,
  input  logic signed [SAMPLE_W-1:0] in_sample_word,
  input  logic [LEN_W-1:0]           in_frame_count,
  input  logic                       in_stereo,
  input  logic [RATE_W-1:0]          in_rate_step,
  input  logic                       in_looping,
  input  logic [PRIO_W-1:0]          in_priority_req,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_left_out,
  output logic signed [SAMPLE_W-1:0] out_right_out,
  output logic [MASK_W-1:0]          out_active_voices
);

  // Commands from the sequencer and status from the datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The sequencer decodes each accepted command and, for a tick, steps
  // through the voices while the datapath advances phases and reads samples.
  svm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  // The datapath holds the voice state, the sample memory, the two mix
  // accumulators and the registered result.
  svm_datapath #(
    .VOICES       (VOICES),
    .SAMPLE_WORDS (SAMPLE_WORDS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_voice          (in_voice),
    .in_address        (in_address),
    .in_sample_word    (in_sample_word),
    .in_frame_count    (in_frame_count),
    .in_stereo         (in_stereo),
    .in_rate_step      (in_rate_step),
    .in_looping        (in_looping),
    .in_priority_req   (in_priority_req),
    .out_valid         (out_valid),
    .out_left_out      (out_left_out),
    .out_right_out     (out_right_out),
    .out_active_voices (out_active_voices)
  );

endmodule
